/* rtl/gdd_pkg.sv */
// Shared widths, constants and calendar tables for the date difference core.
package gdd_pkg;

  localparam int DAY_W       = 5;
  localparam int MON_W       = 4;
  localparam int YEAR_W      = 14;
  localparam int COUNT_W     = 23;
  localparam int ORD_W       = 24;
  localparam int REM_W       = 7;
  localparam int OFS_W       = 9;
  localparam int PROD_W      = 27;
  localparam int RECIP_SHIFT = 19;

  // 5243 / 2^19 is just above 1/100; exact floor for every 14-bit year.
  localparam logic [YEAR_W-1:0] RECIP_100 = 14'd5243;
  localparam logic [YEAR_W-1:0] CENTURY   = 14'd100;

  localparam logic [ORD_W-1:0] COUNT_MAX_MAG = 24'd4194303;
  localparam logic [ORD_W-1:0] COUNT_MIN_MAG = 24'd4194304;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 23'h3FFFFF;
  localparam logic [COUNT_W-1:0] COUNT_MIN = 23'h400000;

  typedef logic [ORD_W-1:0] ord_t;

  // Days in a month of a common year; codes outside 1..12 give 0.
  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                        len = 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before the month in a March-based year (Jan/Feb belong to the prior year).
  function automatic logic [OFS_W-1:0] month_offset(input logic [MON_W-1:0] m);
    logic [OFS_W-1:0] ofs;
    case (m)
      4'd3:    ofs = 9'd0;
      4'd4:    ofs = 9'd31;
      4'd5:    ofs = 9'd61;
      4'd6:    ofs = 9'd92;
      4'd7:    ofs = 9'd122;
      4'd8:    ofs = 9'd153;
      4'd9:    ofs = 9'd184;
      4'd10:   ofs = 9'd214;
      4'd11:   ofs = 9'd245;
      4'd12:   ofs = 9'd275;
      4'd1:    ofs = 9'd306;
      4'd2:    ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

/* rtl/gdd_div100.sv */
// Year divided by 100 through a reciprocal multiply.
module gdd_div100 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [gdd_pkg::YEAR_W-1:0]    dividend,
  output logic                          done,
  output logic [gdd_pkg::YEAR_W-1:0]    quotient,
  output logic [gdd_pkg::REM_W-1:0]     remainder
);
  import gdd_pkg::*;

  logic [YEAR_W-1:0] dvd;
  logic [PROD_W-1:0] prod;
  logic              mul_done;
  logic [YEAR_W-1:0] q_est;
  logic [YEAR_W-1:0] r_full;
  logic [YEAR_W-1:0] quo;
  logic [REM_W-1:0]  rem;

  assign q_est  = YEAR_W'(prod[PROD_W-1:RECIP_SHIFT]);
  assign r_full = dvd - YEAR_W'(q_est * CENTURY);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_done <= 1'b0;
      done     <= 1'b0;
    end else begin
      mul_done <= start;
      done     <= mul_done;
    end
  end

  // First the product is registered, then the quotient and remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      prod <= PROD_W'(dividend) * PROD_W'(RECIP_100);
    end
    if (mul_done) begin
      quo <= q_est;
      rem <= r_full[REM_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

/* rtl/gregorian_date_difference_core.sv */
// Top level: signed day count between two Gregorian dates.
// One item at a time: a new input is taken only in S_IDLE, and a result stalled
// at the output holds the sequencer in S_FIN. Each date passes a reciprocal
// divide by 100 (S_DIV) and ordinal arithmetic (S_ORD1, S_ORD2); then come the
// difference (S_DIFF) and the output register (S_FIN).
// Synchronous reset idles the sequencer and drops any pending result.
module gregorian_date_difference_core #(
  parameter int YEAR_MAX = 9999
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [gdd_pkg::DAY_W-1:0]      start_day,
  input  logic [gdd_pkg::MON_W-1:0]      start_month,
  input  logic [gdd_pkg::YEAR_W-1:0]     start_year,
  input  logic [gdd_pkg::DAY_W-1:0]      end_day,
  input  logic [gdd_pkg::MON_W-1:0]      end_month,
  input  logic [gdd_pkg::YEAR_W-1:0]     end_year,
  input  logic                           include_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [gdd_pkg::COUNT_W-1:0] day_count,
  output logic                           bad_date
);
  import gdd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_ORD1 = 3'd2;
  localparam logic [2:0] S_ORD2 = 3'd3;
  localparam logic [2:0] S_DIFF = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  localparam logic [YEAR_W+1:0] YEAR_LIMIT = (YEAR_W+2)'(YEAR_MAX);

  logic [2:0] state;
  logic       sel;      // 0: start date, 1: end date

  logic [DAY_W-1:0]  sd, ed;
  logic [MON_W-1:0]  sm, em;
  logic [YEAR_W-1:0] sy, ey;
  logic              inc;

  logic [DAY_W-1:0]  cur_d;
  logic [MON_W-1:0]  cur_m;
  logic [YEAR_W-1:0] cur_y;

  logic              div_start;
  logic [YEAR_W-1:0] div_dvd;
  logic              div_done;
  logic [YEAR_W-1:0] div_q;
  logic [REM_W-1:0]  div_r;

  logic [YEAR_W-1:0] yy, qq;
  ord_t              prod;
  logic              ok_cur, ok_s;
  ord_t              ord_s, ord_e;
  ord_t              ord_sum;
  logic              neg;
  ord_t              mag;
  logic signed [ORD_W:0] diff;

  logic              early, leap, month_ok, year_ok, day_ok;
  logic [DAY_W-1:0]  len;
  ord_t              mag_inc;
  logic [COUNT_W-1:0] res;
  logic              accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  assign cur_d = sel ? ed : sd;
  assign cur_m = sel ? em : sm;
  assign cur_y = sel ? ey : sy;

  assign div_start = accept || (state == S_ORD2 && !sel);
  assign div_dvd   = (state == S_IDLE) ? start_year : ey;

  gdd_div100 u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Date checks from y = 100*q + r; y%4 equals r%4.
  always_comb begin
    early    = (cur_m == 4'd1) || (cur_m == 4'd2);
    leap     = ((div_r[1:0] == 2'd0) && (div_r != '0)) ||
               ((div_r == '0) && (div_q[1:0] == 2'd0));
    len      = (cur_m == 4'd2 && leap) ? 5'd29 : month_days(cur_m);
    month_ok = (cur_m >= 4'd1) && (cur_m <= 4'd12);
    year_ok  = (cur_y != '0) && ({2'b00, cur_y} <= YEAR_LIMIT);
    day_ok   = (cur_d != '0) && (cur_d <= len);
  end

  assign ord_sum = prod + ORD_W'(yy >> 2) - ORD_W'(qq) + ORD_W'(qq >> 2)
                 + ORD_W'(month_offset(cur_m)) + ORD_W'(cur_d);

  assign diff    = $signed({1'b0, ord_e}) - $signed({1'b0, ord_s});
  assign mag_inc = mag + ORD_W'(inc);

  always_comb begin
    if (!neg && mag_inc > COUNT_MAX_MAG) begin
      res = COUNT_MAX;
    end else if (neg && mag_inc > COUNT_MIN_MAG) begin
      res = COUNT_MIN;
    end else if (neg) begin
      res = COUNT_W'(~mag_inc + 1'b1);
    end else begin
      res = mag_inc[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sel       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FIN && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            sel   <= 1'b0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_ORD1;
          end
        end
        S_ORD1: begin
          state <= S_ORD2;
        end
        S_ORD2: begin
          if (!sel) begin
            sel   <= 1'b1;
            state <= S_DIV;
          end else begin
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sd  <= start_day;
      sm  <= start_month;
      sy  <= start_year;
      ed  <= end_day;
      em  <= end_month;
      ey  <= end_year;
      inc <= include_end;
    end
    if (state == S_ORD1) begin
      // Jan/Feb count as months 13/14 of the prior year.
      yy     <= early ? cur_y - 1'b1 : cur_y;
      qq     <= (early && div_r == '0) ? div_q - 1'b1 : div_q;
      prod   <= ORD_W'(early ? cur_y - 1'b1 : cur_y) * ORD_W'(365);
      ok_cur <= month_ok && year_ok && day_ok;
    end
    if (state == S_ORD2) begin
      if (!sel) begin
        ord_s <= ord_sum;
        ok_s  <= ok_cur;
      end else begin
        ord_e <= ord_sum;
      end
    end
    if (state == S_DIFF) begin
      neg <= diff[ORD_W];
      mag <= diff[ORD_W] ? ORD_W'(-diff) : diff[ORD_W-1:0];
    end
    if (state == S_FIN && (!out_valid || !out_stall)) begin
      if (ok_s && ok_cur) begin
        day_count <= $signed(res);
        bad_date  <= 1'b0;
      end else begin
        day_count <= '0;
        bad_date  <= 1'b1;
      end
    end
  end

endmodule

/* rtl/gdd_checker.sv */
// Port-level checks for the date difference core, bound to the top level.
module gdd_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [gdd_pkg::COUNT_W-1:0] day_count,
  input logic                               bad_date
);
  import gdd_pkg::*;

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_date |-> day_count == '0)
    else $error("bad date result with nonzero count");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(day_count) && $stable(bad_date))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while item in progress");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in progress");

endmodule

bind gregorian_date_difference_core gdd_checker u_gdd_checker (.*);

/* tb/tb_gregorian_date_difference_core.sv */
// Self-checking testbench for the Gregorian date difference core.
`timescale 1ns / 1ps

module tb_gregorian_date_difference_core;

  localparam int HALF_PERIOD     = 5;
  localparam int RESET_CYCLES    = 12;
  localparam int YEAR_LIMIT      = 9999;
  localparam int DRAIN_CYCLES    = 40;    // well over the core's latency
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int MAX_PRINTS      = 20;
  localparam int FEBRUARY        = 2;
  localparam int DECEMBER        = 12;
  localparam int MONTHS          = 12;
  localparam int DAY_ALL_ONES    = (1 << gdd_pkg::DAY_W) - 1;
  localparam int MON_ALL_ONES    = (1 << gdd_pkg::MON_W) - 1;
  localparam int YEAR_ALL_ONES   = (1 << gdd_pkg::YEAR_W) - 1;
  localparam longint COUNT_HI    = (longint'(1) << (gdd_pkg::COUNT_W - 1)) - 1;
  localparam longint COUNT_LO    = -(longint'(1) << (gdd_pkg::COUNT_W - 1));

  typedef logic [gdd_pkg::DAY_W-1:0]  day_t;
  typedef logic [gdd_pkg::MON_W-1:0]  month_t;
  typedef logic [gdd_pkg::YEAR_W-1:0] year_t;

  typedef struct packed {
    day_t   day;
    month_t month;
    year_t  year;
  } date_t;

  typedef struct packed {
    date_t from_date;
    date_t to_date;
    logic  include_end;
  } date_pair_t;

  typedef struct packed {
    logic signed [gdd_pkg::COUNT_W-1:0] count;
    logic                               bad;
  } day_span_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [gdd_pkg::COUNT_W-1:0] day_count;
  logic bad_date;

  date_pair_t held_pair = '0;
  wire day_t   start_day   = held_pair.from_date.day;
  wire month_t start_month = held_pair.from_date.month;
  wire year_t  start_year  = held_pair.from_date.year;
  wire day_t   end_day     = held_pair.to_date.day;
  wire month_t end_month   = held_pair.to_date.month;
  wire year_t  end_year    = held_pair.to_date.year;
  wire         include_end = held_pair.include_end;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  date_pair_t pending_pairs[$];
  day_span_t  expected_spans[$];
  day_span_t  want_span;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int mismatches    = 0;
  int results_seen  = 0;
  int bad_seen      = 0;
  int neg_seen      = 0;
  int directed_cnt  = 0;
  int quiet_cycles  = 0;

  gregorian_date_difference_core #(.YEAR_MAX(YEAR_LIMIT)) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .start_day   (start_day),
    .start_month (start_month),
    .start_year  (start_year),
    .end_day     (end_day),
    .end_month   (end_month),
    .end_year    (end_year),
    .include_end (include_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .day_count   (day_count),
    .bad_date    (bad_date)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------- calendar predictor ----------------

  function automatic bit leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_length(int m, int y);
    int len;
    case (m)
      1, 3, 5, 7, 8, 10, DECEMBER: len = 31;
      4, 6, 9, 11:                 len = 30;
      FEBRUARY:                    len = leap_year(y) ? 29 : 28;
      default:                     len = 0;
    endcase
    return len;
  endfunction

  function automatic bit date_ok(date_t dt);
    return (dt.year >= 1) && (dt.year <= YEAR_LIMIT) && (dt.day >= 1) &&
           (dt.day <= month_length(dt.month, dt.year));
  endfunction

  // Day number with years starting in March, so the leap day sits at year end.
  function automatic longint date_ordinal(date_t dt);
    longint y;
    longint m;
    y = dt.year;
    m = dt.month;
    if (m <= FEBRUARY) begin
      y = y - 1;
      m = m + MONTHS;
    end
    return 365 * y + y / 4 - y / 100 + y / 400 + (153 * (m - 3) + 2) / 5 + dt.day;
  endfunction

  function automatic day_span_t predict_span(date_pair_t p);
    day_span_t s;
    longint diff;
    longint mag;
    s.bad   = !(date_ok(p.from_date) && date_ok(p.to_date));
    s.count = '0;
    if (!s.bad) begin
      diff = date_ordinal(p.to_date) - date_ordinal(p.from_date);
      mag  = (diff < 0) ? -diff : diff;
      if (p.include_end) mag = mag + 1;
      diff = (diff < 0) ? -mag : mag;
      if (diff > COUNT_HI) diff = COUNT_HI;
      if (diff < COUNT_LO) diff = COUNT_LO;
      s.count = diff[gdd_pkg::COUNT_W-1:0];
    end
    return s;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic date_t make_date(int d, int m, int y);
    date_t dt;
    dt.day   = day_t'(d);
    dt.month = month_t'(m);
    dt.year  = year_t'(y);
    return dt;
  endfunction

  function automatic date_pair_t pair_of(date_t a, date_t b, bit inc);
    date_pair_t p;
    p.from_date   = a;
    p.to_date     = b;
    p.include_end = inc;
    return p;
  endfunction

  function automatic date_t rand_date(int ylo, int yhi);
    int y;
    int m;
    y = $urandom_range(yhi, ylo);
    m = $urandom_range(MONTHS, 1);
    return make_date($urandom_range(month_length(m, y), 1), m, y);
  endfunction

  // Any bit pattern; mostly not a real date.
  function automatic date_t raw_date();
    return make_date($urandom_range(DAY_ALL_ONES, 0), $urandom_range(MON_ALL_ONES, 0),
                     $urandom_range(YEAR_ALL_ONES, 0));
  endfunction

  // Century years, leap years, range ends; month ends and Feb 29.
  function automatic date_t corner_date();
    int y;
    int m;
    int d;
    case ($urandom_range(3))
      0:       y = $urandom_range(YEAR_LIMIT / 100, 1) * 100;
      1:       y = $urandom_range(YEAR_LIMIT / 4, 1) * 4;
      2:       y = $urandom_range(1) ? $urandom_range(3, 1) : YEAR_LIMIT - $urandom_range(2);
      default: y = $urandom_range(YEAR_LIMIT, 1);
    endcase
    m = $urandom_range(1) ? FEBRUARY : $urandom_range(MONTHS, 1);
    case ($urandom_range(3))
      0:       d = 1;
      1:       d = month_length(m, y);
      2:       d = 29;
      default: d = $urandom_range(month_length(m, y), 1);
    endcase
    return make_date(d, m, y);
  endfunction

  function automatic date_pair_t random_pair();
    date_pair_t p;
    int pick;
    int y;
    pick          = $urandom_range(99);
    p.include_end = $urandom_range(1);
    p.from_date   = rand_date(1, YEAR_LIMIT);
    if (pick < 35) begin
      p.to_date = rand_date(1, YEAR_LIMIT);
    end else if (pick < 60) begin
      // nearby dates: month and year rollover in short spans
      y = int'(p.from_date.year) + int'($urandom_range(4)) - 2;
      if (y < 1) y = 1;
      if (y > YEAR_LIMIT) y = YEAR_LIMIT;
      p.to_date = rand_date(y, y);
    end else if (pick < 72) begin
      p.from_date = corner_date();
      p.to_date   = corner_date();
    end else if (pick < 80) begin
      p.to_date = p.from_date;
    end else if (pick < 90) begin
      p.to_date = rand_date(1, YEAR_LIMIT);
      if ($urandom_range(1)) p.from_date = raw_date();
      else p.to_date = raw_date();
    end else begin
      p.from_date = raw_date();
      p.to_date   = raw_date();
    end
    return p;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_pairs.size() != 0 || in_valid || expected_spans.size() != 0);
  endtask

  // ---------------- driver ----------------

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_fire) expected_spans.push_back(predict_span(held_pair));
      if (!in_valid || !in_stall) begin
        if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          held_pair <= pending_pairs.pop_front();
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_fire) begin
        results_seen++;
        if (expected_spans.size() == 0) begin
          report_mismatch($sformatf("unexpected result: day_count %0d bad_date %0b",
                                    day_count, bad_date));
        end else begin
          want_span = expected_spans.pop_front();
          if (bad_date !== want_span.bad)
            report_mismatch($sformatf("result %0d: bad_date %0b, expected %0b",
                                      results_seen, bad_date, want_span.bad));
          if (day_count !== want_span.count)
            report_mismatch($sformatf("result %0d: day_count %0d, expected %0d",
                                      results_seen, day_count, want_span.count));
          if (want_span.bad) bad_seen++;
          else if (want_span.count < 0) neg_seen++;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    if (rst || in_fire || out_fire) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, expected_spans.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------- sequence ----------------

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // equal dates, full range both ways, rollovers, leap rules
    pending_pairs.push_back(pair_of(make_date(15, 6, 2024), make_date(15, 6, 2024), 0));
    pending_pairs.push_back(pair_of(make_date(15, 6, 2024), make_date(15, 6, 2024), 1));
    pending_pairs.push_back(pair_of(make_date(1, 1, 1), make_date(31, DECEMBER, YEAR_LIMIT), 1));
    pending_pairs.push_back(pair_of(make_date(31, DECEMBER, YEAR_LIMIT), make_date(1, 1, 1), 1));
    pending_pairs.push_back(pair_of(make_date(1, 1, 1), make_date(31, DECEMBER, YEAR_LIMIT), 0));
    pending_pairs.push_back(pair_of(make_date(1, 1, 1), make_date(1, 1, 1), 1));
    pending_pairs.push_back(pair_of(make_date(31, DECEMBER, YEAR_LIMIT),
                                    make_date(31, DECEMBER, YEAR_LIMIT), 0));
    pending_pairs.push_back(pair_of(make_date(31, 1, 2023), make_date(1, FEBRUARY, 2023), 0));
    pending_pairs.push_back(pair_of(make_date(31, DECEMBER, 1999), make_date(1, 1, 2000), 0));
    pending_pairs.push_back(pair_of(make_date(28, FEBRUARY, 2000), make_date(1, 3, 2000), 0));
    pending_pairs.push_back(pair_of(make_date(28, FEBRUARY, 1900), make_date(1, 3, 1900), 0));
    pending_pairs.push_back(pair_of(make_date(29, FEBRUARY, 2024), make_date(1, 3, 2024), 1));
    pending_pairs.push_back(pair_of(make_date(1, 3, 2024), make_date(29, FEBRUARY, 2024), 1));
    pending_pairs.push_back(pair_of(make_date(29, FEBRUARY, 2000),
                                    make_date(29, FEBRUARY, 2400), 0));
    // invalid dates on either side
    pending_pairs.push_back(pair_of(make_date(29, FEBRUARY, 1900), make_date(1, 3, 1900), 0));
    pending_pairs.push_back(pair_of(make_date(1, 3, 2023), make_date(29, FEBRUARY, 2023), 1));
    pending_pairs.push_back(pair_of(make_date(0, 5, 2010), make_date(1, 5, 2010), 0));
    pending_pairs.push_back(pair_of(make_date(1, 5, 2010), make_date(31, 4, 2010), 0));
    pending_pairs.push_back(pair_of(make_date(1, 0, 2010), make_date(1, 5, 2010), 0));
    pending_pairs.push_back(pair_of(make_date(1, 5, 2010), make_date(1, MONTHS + 1, 2010), 1));
    pending_pairs.push_back(pair_of(make_date(DAY_ALL_ONES, MON_ALL_ONES, YEAR_ALL_ONES),
                                    make_date(1, 1, 1), 1));
    pending_pairs.push_back(pair_of(make_date(1, 1, 0), make_date(1, 1, 1), 0));
    pending_pairs.push_back(pair_of(make_date(1, 1, YEAR_LIMIT),
                                    make_date(1, 1, YEAR_LIMIT + 1), 0));
    pending_pairs.push_back(pair_of(make_date(0, 0, 0), make_date(0, 0, 0), 1));
    directed_cnt = pending_pairs.size();
    wait_idle();

    // random traffic under each idle mix; each phase drains before the next
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 50; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 50; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
      repeat (ITEMS_PER_PHASE) pending_pairs.push_back(random_pair());
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d date pairs (%0d directed): %0d invalid, %0d negative spans",
             results_seen, directed_cnt, bad_seen, neg_seen);
    $display("Idle mixes: none, sender 50%%, receiver 50%%, both 14%%; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
